>>> rtl/htbd_pkg.sv
// ============================================================================
// htbd_pkg: shared types and constants for the Huffman tree bit decoder
// Node entry layout, opcodes and refresh sequencer state encoding.
// ============================================================================
package htbd_pkg;

    // Field widths fixed by the stream format
    localparam int IDX_W = 9;
    localparam int SYM_W = 8;

    // Default table depth
    localparam int NODE_COUNT_DEF = 512;

    // Request opcodes (carried on tuser)
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // One node table entry
    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } t_node;

    // Root cache refresh sequencer, one-hot
    typedef enum logic [3:0] {
        RF_IDLE = 4'b0001,
        RF_ROOT = 4'b0010,
        RF_KIDS = 4'b0100,
        RF_DONE = 4'b1000
    } t_rf_state;

endpackage

>>> rtl/huffman_tree_bit_decoder.sv
// ============================================================================
// huffman_tree_bit_decoder: code tree walk, one code bit per request
// Node table in a dual-read memory; child entries of the current node and of
// the root are kept ready so each decode bit resolves without waiting on a read.
// ============================================================================
//
//  channel   | dir | payload
//  ----------+-----+-----------------------------------------------------------
//  s_axis    | in  | tuser: opcode; tdata: node_index, left_child, right_child,
//            |     |        leaf_flag, leaf_symbol, code_bit
//  m_axis    | out | tuser: walk_error; tdata: decoded_symbol
//  cfg       | in  | root_node (9 bits)
//
//  A decode is resolved from the input register into the result register.
//  Decodes stream at one per clock while results are taken and no refresh runs,
//  both children of each new node read in its step. A load writes the entry and
//  refreshes the cached root and children entries, as does a root write.
//  Reset clears control state only; the node table is not cleared.
//  A stalled m_axis holds decode requests in the input register; loads proceed.
// ============================================================================
module huffman_tree_bit_decoder #(
    parameter int NODE_COUNT = htbd_pkg::NODE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [8:0] node_index, [17:9] left_child, [26:18] right_child, [27] leaf_flag,
    // [35:28] leaf_symbol, [36] code_bit, [39:37] zero
    input  logic [39:0] s_axis_tdata,
    // [0] opcode
    input  logic [0:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] decoded_symbol
    output logic [7:0]  m_axis_tdata,
    // [0] walk_error
    output logic [0:0]  m_axis_tuser,
    // root register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);

    localparam int IW  = htbd_pkg::IDX_W;
    localparam int AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CW  = ((AW > IW) ? AW : IW) + 1;
    localparam logic [CW-1:0] LIMIT = CW'(NODE_COUNT);

    // Index range check and memory address
    function automatic logic f_in_range(input logic [IW-1:0] idx);
        return CW'(idx) < LIMIT;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] idx);
        logic [CW-1:0] wide;
        wide = CW'(idx);
        return wide[AW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    htbd_pkg::t_node      mem [NODE_COUNT];

    logic                 r_in_valid;
    logic                 r_in_op;
    htbd_pkg::t_node      r_in_node;
    logic [IW-1:0]        r_in_idx;
    logic                 r_in_bit;

    logic [IW-1:0]        r_root;
    htbd_pkg::t_rf_state  r_rf_state, n_rf_state;
    logic                 r_rf_load;

    htbd_pkg::t_node      r_rd0, r_rd1;
    logic                 r_oor0, r_oor1;

    logic                 r_root_leaf;
    htbd_pkg::t_node      r_rl, r_rr;

    logic                 r_cur_leaf, n_cur_leaf;
    logic                 r_from_mem, n_from_mem;
    htbd_pkg::t_node      r_cl, r_cr, n_cl, n_cr;

    logic                 r_out_valid;
    logic [7:0]           r_out_sym;
    logic                 r_out_err;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    htbd_pkg::t_node      rd0, rd1, cl, cr, ch;
    logic [IW-1:0]        a0, a1;
    logic                 out_free, rf_idle, go, go_load, go_dec;
    logic                 res_valid, res_err;
    logic [7:0]           res_sym;
    logic                 to_root, step_in;
    logic                 cfg_go;

    // Read data, zero beyond the table
    assign rd0 = r_oor0 ? htbd_pkg::t_node'('0) : r_rd0;
    assign rd1 = r_oor1 ? htbd_pkg::t_node'('0) : r_rd1;

    // Children of the current node
    assign cl = r_from_mem ? rd0 : r_cl;
    assign cr = r_from_mem ? rd1 : r_cr;
    assign ch = r_in_bit ? cr : cl;

    // Handshake
    assign rf_idle       = (r_rf_state == htbd_pkg::RF_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign go            = r_in_valid && rf_idle &&
                           ((r_in_op == htbd_pkg::OP_LOAD) || out_free);
    assign go_load       = go && (r_in_op == htbd_pkg::OP_LOAD);
    assign go_dec        = go && (r_in_op == htbd_pkg::OP_DECODE);
    assign s_axis_tready = !r_in_valid || go;
    assign o_cfg_ready   = rf_idle && !r_in_valid;
    assign cfg_go        = i_cfg_valid && o_cfg_ready;

    // Decode step
    always_comb begin
        res_valid = 1'b0;
        res_err   = 1'b0;
        res_sym   = '0;
        to_root   = 1'b0;
        step_in   = 1'b0;
        if (go_dec) begin
            if (r_cur_leaf) begin
                res_valid = 1'b1;
                res_err   = 1'b1;
                to_root   = 1'b1;
            end else if (ch.leaf) begin
                res_valid = 1'b1;
                res_sym   = ch.sym;
                to_root   = 1'b1;
            end else begin
                step_in   = 1'b1;
            end
        end
    end

    // Read port addresses
    always_comb begin
        a0 = '0;
        a1 = '0;
        if (r_rf_state == htbd_pkg::RF_ROOT) begin
            a0 = r_root;
        end else if (r_rf_state == htbd_pkg::RF_KIDS) begin
            a0 = rd0.left;
            a1 = rd0.right;
        end else if (step_in) begin
            a0 = ch.left;
            a1 = ch.right;
        end
    end

    // Refresh sequencer next state
    always_comb begin
        n_rf_state = r_rf_state;
        unique case (r_rf_state)
            htbd_pkg::RF_IDLE: begin
                if (go_load || cfg_go) n_rf_state = htbd_pkg::RF_ROOT;
            end
            htbd_pkg::RF_ROOT: n_rf_state = htbd_pkg::RF_KIDS;
            htbd_pkg::RF_KIDS: n_rf_state = htbd_pkg::RF_DONE;
            htbd_pkg::RF_DONE: n_rf_state = htbd_pkg::RF_IDLE;
            default:           n_rf_state = htbd_pkg::RF_IDLE;
        endcase
    end

    // Current node caches next state
    always_comb begin
        n_cur_leaf = r_cur_leaf;
        n_from_mem = 1'b0;
        n_cl       = r_from_mem ? rd0 : r_cl;
        n_cr       = r_from_mem ? rd1 : r_cr;
        if ((r_rf_state == htbd_pkg::RF_DONE) && r_rf_load) begin
            n_cur_leaf = r_root_leaf;
            n_cl       = rd0;
            n_cr       = rd1;
        end else if (to_root) begin
            n_cur_leaf = r_root_leaf;
            n_cl       = r_rl;
            n_cr       = r_rr;
        end else if (step_in) begin
            n_cur_leaf = 1'b0;
            n_from_mem = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Node table: one write port, two registered read ports
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (go_load && f_in_range(r_in_idx)) begin
            mem[f_addr(r_in_idx)] <= r_in_node;
        end
        r_rd0  <= mem[f_addr(a0)];
        r_rd1  <= mem[f_addr(a1)];
        r_oor0 <= !f_in_range(a0);
        r_oor1 <= !f_in_range(a1);
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op        <= s_axis_tuser[0];
            r_in_idx       <= s_axis_tdata[8:0];
            r_in_node.left <= s_axis_tdata[17:9];
            r_in_node.right<= s_axis_tdata[26:18];
            r_in_node.leaf <= s_axis_tdata[27];
            r_in_node.sym  <= s_axis_tdata[35:28];
            r_in_bit       <= s_axis_tdata[36];
        end
    end

    // ------------------------------------------------------------------
    // Root register, sequencer and walk state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root      <= '0;
            r_rf_state  <= htbd_pkg::RF_IDLE;
            r_rf_load   <= 1'b0;
            r_root_leaf <= 1'b0;
            r_cur_leaf  <= 1'b0;
            r_from_mem  <= 1'b0;
        end else begin
            r_rf_state <= n_rf_state;
            r_cur_leaf <= n_cur_leaf;
            r_from_mem <= n_from_mem;
            if (cfg_go) begin
                r_root    <= i_cfg_data;
                r_rf_load <= 1'b0;
            end else if (go_load) begin
                r_rf_load <= 1'b1;
            end
            if (r_rf_state == htbd_pkg::RF_KIDS) begin
                r_root_leaf <= rd0.leaf;
            end
        end
    end

    // Cached entries (payload, no reset)
    always_ff @(posedge i_clk) begin
        r_cl <= n_cl;
        r_cr <= n_cr;
        if (r_rf_state == htbd_pkg::RF_DONE) begin
            r_rl <= rd0;
            r_rr <= rd1;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_sym <= res_sym;
            r_out_err <= res_err;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_sym;
    assign m_axis_tuser[0] = r_out_err;

endmodule

>>> test/testbench.sv
// ============================================================================
// Huffman tree bit decoder testbench
// Loads code trees into the node table and streams code bits through the
// decoder. A tree-walk tracker predicts each symbol or walk error and checks
// the result stream in order, under random idling and back-pressure.
// ============================================================================

// One expected result: leaf symbol and walk error flag
typedef struct packed {
    logic [htbd_pkg::SYM_W-1:0] sym;
    logic                       err;
} t_walk_result;

// Tracks the tree walk and holds the symbols still due on the result stream
class code_walk_tracker;
    htbd_pkg::t_node            nodes [htbd_pkg::NODE_COUNT_DEF];
    logic [htbd_pkg::IDX_W-1:0] cur_node;
    logic [htbd_pkg::IDX_W-1:0] root_node;
    t_walk_result               pending_symbols [$];
    int                         mismatches;

    function new();
        cur_node   = '0;
        root_node  = '0;
        mismatches = 0;
    endfunction

    function void set_root(logic [htbd_pkg::IDX_W-1:0] idx);
        root_node = idx;
    endfunction

    function int outstanding();
        return pending_symbols.size();
    endfunction

    // Apply one accepted request: a node load or one step of the walk
    function void note_request(logic op, logic [39:0] d);
        htbd_pkg::t_node            here;
        htbd_pkg::t_node            child;
        logic [htbd_pkg::IDX_W-1:0] step_to;
        t_walk_result               res;
        if (op == htbd_pkg::OP_LOAD) begin
            here.left  = d[17:9];
            here.right = d[26:18];
            here.leaf  = d[27];
            here.sym   = d[35:28];
            nodes[d[8:0]] = here;
            cur_node = root_node;
        end else begin
            here = nodes[cur_node];
            if (here.leaf) begin
                // bit arrived while sitting on a leaf
                res.sym = '0;
                res.err = 1'b1;
                pending_symbols.push_back(res);
                cur_node = root_node;
            end else begin
                step_to = d[36] ? here.right : here.left;
                child   = nodes[step_to];
                if (child.leaf) begin
                    res.sym = child.sym;
                    res.err = 1'b0;
                    pending_symbols.push_back(res);
                    cur_node = root_node;
                end else begin
                    cur_node = step_to;
                end
            end
        end
    endfunction

    // Compare one accepted result with the oldest expected one
    function void check_result(logic [htbd_pkg::SYM_W-1:0] sym, logic err);
        t_walk_result want;
        if (pending_symbols.size() == 0) begin
            $display("%0t: result with none expected, actual sym=%h err=%b", $time, sym, err);
            mismatches++;
        end else begin
            want = pending_symbols.pop_front();
            if (sym !== want.sym) begin
                $display("%0t: decoded_symbol expected %h actual %h", $time, want.sym, sym);
                mismatches++;
            end
            if (err !== want.err) begin
                $display("%0t: walk_error expected %b actual %b", $time, want.err, err);
                mismatches++;
            end
        end
    endfunction
endclass

module testbench;

    localparam int NODES         = htbd_pkg::NODE_COUNT_DEF;
    localparam int ITEM_TARGET   = 1700;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [8:0]           i_cfg_data;

    code_walk_tracker     walk = new();
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   hold_request;
    int                   sent_items;
    int                   quiet_cycles;

    // Tree currently loaded, by slot; leaves occupy the low slots
    logic [htbd_pkg::IDX_W-1:0] slot_idx    [NODES];
    logic [39:0]                slot_word   [NODES];
    int                         slot_parent [NODES];
    bit                         slot_side   [NODES];
    int                         tree_slots;
    int                         root_slot;

    huffman_tree_bit_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side ready: random idling, or a long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Handshake monitor and stall watchdog
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            walk.note_request(s_axis_tuser[0], s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready)
            walk.check_result(m_axis_tdata, m_axis_tuser[0]);
        if (i_cfg_valid && o_cfg_ready)
            walk.set_root(i_cfg_data);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [39:0] node_word(logic [htbd_pkg::IDX_W-1:0] idx,
                                              logic [htbd_pkg::IDX_W-1:0] l,
                                              logic [htbd_pkg::IDX_W-1:0] r, logic leaf,
                                              logic [htbd_pkg::SYM_W-1:0] sym);
        return {3'b0, 1'b0, sym, leaf, r, l, idx};
    endfunction

    // Offer one request, with random idle cycles ahead of it
    task automatic send_request(input logic op, input logic [39:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sent_items++;
    endtask

    // Load; the code bit is don't-care and gets random
    task automatic send_load(input logic [39:0] word);
        word[36] = 1'($urandom_range(1));
        send_request(htbd_pkg::OP_LOAD, word);
    endtask

    // Decode; unused fields get random
    task automatic send_bit(input bit b);
        send_request(htbd_pkg::OP_DECODE, {3'b0, b, 4'($urandom), 32'($urandom)});
    endtask

    // Hold the input until every expected result is out, then let it settle
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (walk.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_root(input logic [htbd_pkg::IDX_W-1:0] idx);
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= idx;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
    endtask

    // Build a random full tree over distinct table entries, point the root
    // register at it and load its nodes in random order
    task automatic load_random_tree(input int leaves, input bit chain);
        int pick  [NODES];
        int order [NODES];
        int pool  [$];
        int a, x, y, slot, j, tmp;
        tree_slots = 2 * leaves - 1;
        for (j = 0; j < NODES; j++)
            pick[j] = j;
        for (j = 0; j < tree_slots; j++) begin
            a = $urandom_range(NODES - 1, j);
            tmp = pick[j]; pick[j] = pick[a]; pick[a] = tmp;
            slot_idx[j] = 9'(pick[j]);
            order[j]    = j;
        end
        // leaves keep random child fields, never followed
        for (j = 0; j < leaves; j++) begin
            slot_word[j] = node_word(slot_idx[j], 9'($urandom), 9'($urandom), 1'b1,
                                     8'($urandom));
            pool.push_back(j);
        end
        // merge subtrees; chain mode takes newest after first merge: deep tree
        for (slot = leaves; slot < tree_slots; slot++) begin
            a = (chain && slot > leaves) ? pool.size() - 1 : $urandom_range(pool.size() - 1);
            x = pool[a];
            pool.delete(a);
            a = $urandom_range(pool.size() - 1);
            y = pool[a];
            pool.delete(a);
            if ($urandom_range(1)) begin
                tmp = x; x = y; y = tmp;
            end
            slot_parent[x] = slot; slot_side[x] = 1'b0;
            slot_parent[y] = slot; slot_side[y] = 1'b1;
            slot_word[slot] = node_word(slot_idx[slot], slot_idx[x], slot_idx[y], 1'b0,
                                        8'($urandom));
            pool.push_back(slot);
        end
        root_slot = tree_slots - 1;
        write_root(slot_idx[root_slot]);
        for (j = tree_slots - 1; j > 0; j--) begin
            a = $urandom_range(j);
            tmp = order[j]; order[j] = order[a]; order[a] = tmp;
        end
        for (j = 0; j < tree_slots; j++)
            send_load(slot_word[order[j]]);
    endtask

    // Stream codewords of random leaves, with some broken codewords and
    // some root rewrites in the middle of a codeword; stops at the item target
    task automatic stream_symbols(input int count);
        bit path [$];
        int s, j, n, roll, cut;
        for (n = 0; n < count && sent_items < ITEM_TARGET; n++) begin
            if (tree_slots == 1) begin
                // root is a leaf: every bit is a walk error
                send_bit(1'($urandom_range(1)));
                continue;
            end
            s = $urandom_range((tree_slots + 1) / 2 - 1);
            path = {};
            while (s != root_slot) begin
                path.push_front(slot_side[s]);
                s = slot_parent[s];
            end
            roll = $urandom_range(99);
            if (roll < 7) begin
                // random bits, then a reload returns the walk to the root
                for (j = $urandom_range(3, 1); j > 0; j--)
                    send_bit(1'($urandom_range(1)));
                send_load(slot_word[$urandom_range(tree_slots - 1)]);
            end else if (roll < 10 && path.size() >= 2) begin
                // root rewrite mid-codeword must not move the walk
                cut = $urandom_range(path.size() - 1, 1);
                for (j = 0; j < cut; j++)
                    send_bit(path[j]);
                write_root(slot_idx[root_slot]);
                for (j = cut; j < path.size(); j++)
                    send_bit(path[j]);
            end else begin
                for (j = 0; j < path.size(); j++)
                    send_bit(path[j]);
            end
        end
    endtask

    // Stimulus
    initial begin : stimulus
        int  leaves;
        int  roll;
        bit  held;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        send_idle_pct = 18;
        recv_idle_pct = 83;
        hold_request  = 0;
        sent_items    = 0;
        quiet_cycles  = 0;
        held          = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Small fixed tree at root 0: 0 -> (1, 2), 2 -> (3, 511)
        send_load(node_word(9'd0, 9'd1, 9'd2, 1'b0, 8'h00));
        send_load(node_word(9'd1, 9'd511, 9'd0, 1'b1, 8'h00));
        send_load(node_word(9'd2, 9'd3, 9'd511, 1'b0, 8'h3C));
        send_load(node_word(9'd3, 9'd0, 9'd511, 1'b1, 8'hFF));
        send_load(node_word(9'd511, 9'd0, 9'd0, 1'b1, 8'h5A));
        send_bit(1'b0);                 // leaf 1
        send_bit(1'b1);                 // internal 2
        send_bit(1'b1);                 // leaf 511
        send_bit(1'b1);
        send_bit(1'b0);                 // leaf 3
        // load in mid-walk returns to root
        send_bit(1'b1);
        send_load(node_word(9'd1, 9'd511, 9'd0, 1'b1, 8'h00));
        send_bit(1'b0);                 // leaf 1
        // root moved in mid-walk, walk stays at node 2
        send_bit(1'b1);
        write_root(9'd2);
        send_bit(1'b0);                 // leaf 3, back to root 2
        send_bit(1'b1);                 // leaf 511
        // root on a leaf
        write_root(9'd511);
        send_bit(1'b0);                 // leaf 3 from node 2, walk to 511
        send_bit(1'b0);                 // walk error
        send_bit(1'b1);                 // walk error
        write_root(9'd0);
        send_bit(1'b1);                 // still on leaf 511: walk error
        send_bit(1'b0);                 // leaf 1

        // Random trees and codeword streams
        while (sent_items < ITEM_TARGET) begin
            if (sent_items < ITEM_TARGET / 3) begin
                send_idle_pct = 18;
                recv_idle_pct = 83;
            end else if (sent_items < 2 * ITEM_TARGET / 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 18;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            roll = $urandom_range(99);
            if (roll < 6)
                leaves = 1;
            else if (roll < 12)
                leaves = $urandom_range(100, 33);
            else
                leaves = $urandom_range(12, 2);
            load_random_tree(leaves, $urandom_range(3) == 0);
            // one long result-side hold-off while requests keep coming
            if (!held && send_idle_pct == 0) begin
                hold_request = HOLD_CYCLES;
                held         = 1'b1;
            end
            stream_symbols(leaves == 1 ? 8 : $urandom_range(30, 10));
        end

        wait_results_drained();
        if (walk.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/htbd_pkg.sv
rtl/huffman_tree_bit_decoder.sv
test/testbench.sv
